// File: rtl/core/gcmf_pkg.sv
// gcmf_pkg: shared types and constants for the gray cross mean filter core
// used by every module under rtl/core; no dependencies

package gcmf_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int WidthW   = 11;
  localparam int HeightW  = 16;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;
  localparam int GrayW    = 8;
  localparam int LumaW    = 24;
  localparam int SumW     = 11;
  localparam int CntW     = 3;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);

  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [WidthW-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HeightW-1:0] HEIGHT_RESET = 16'd768;

  localparam logic [15:0] LUMA_R = 16'd19595;
  localparam logic [15:0] LUMA_G = 16'd38470;
  localparam logic [15:0] LUMA_B = 16'd7471;

  // truncating division by 3 and 5 through reciprocals, exact for sums below 2048
  localparam int Recip3 = 683;
  localparam int Shift3 = 11;
  localparam int Recip5 = 3277;
  localparam int Shift5 = 14;
  localparam int P3W    = SumW + 10;
  localparam int P5W    = SumW + 12;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_PIXEL,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ColW-1:0]  col;
    logic [GrayW-1:0] gray;
    logic             has_up;
    logic             has_left;
    logic             has_right;
    logic             last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: rtl/core/gray_cross_mean_filter_core.sv
// gray_cross_mean_filter_core: top level of the rgb to gray cross mean filter
// depends on gcmf_pkg, gcmf_front, gcmf_fifo and gcmf_back
//
// usage:
//   input channel (in_valid/in_ready): one transaction per pixel in raster order
//   (kind = 0, red/green/blue), then one flush transaction (kind = 1) per pixel
//   of the last row once the final pixel is in. pixels after the final one and
//   flushes before it are taken and dropped.
//   output channel (out_valid/out_ready): one transaction per pixel in raster
//   order; a pixel's result leaves once the pixel below it has been taken, the
//   last row leaves on flushes, and last_pixel marks the final result.
//   configuration: cfg_we with cfg_index 0 (image_width) or 1 (image_height)
//   writes a register and restarts the image; it must be written only while
//   idle, which the core itself does not enforce. the back end takes one item
//   at a time: line store read, cross sum and store write, then divide and
//   result load, with first-row pixels done after the store write; it takes
//   no new item before it is through with the last. a 4-entry queue decouples
//   the input side from the back end.
//   reset: counters cleared, width 1024, height 768; line stores are not
//   cleared; within an image no value read from them is used before it is written.
//   a stalled receiver holds the result register; the back end waits and the
//   queue fills, after which in_ready drops.

module gray_cross_mean_filter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [gcmf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [gcmf_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     filtered_value,
  output logic                           last_pixel
);

  gcmf_pkg::q_status_t q_status;
  gcmf_pkg::item_t     push_item;
  gcmf_pkg::item_t     head;
  logic                push;
  logic                pop;

  gcmf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  gcmf_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  gcmf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_status       (q_status),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_value (filtered_value),
    .last_pixel     (last_pixel)
  );

endmodule

// File: rtl/core/gcmf_front.sv
// gcmf_front: configuration registers, luma conversion and item classification
// depends on gcmf_pkg; feeds classified work into gcmf_fifo

module gcmf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gcmf_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [gcmf_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              kind,
  input  logic [7:0]                        red,
  input  logic [7:0]                        green,
  input  logic [7:0]                        blue,
  input  gcmf_pkg::q_status_t               q_status,
  output logic                              push,
  output gcmf_pkg::item_t                   push_item
);

  logic [gcmf_pkg::WidthW-1:0]  image_width;
  logic [gcmf_pkg::HeightW-1:0] image_height;
  logic [gcmf_pkg::ColW-1:0]    in_column;
  logic [gcmf_pkg::HeightW-1:0] in_row;
  logic [gcmf_pkg::ColW-1:0]    out_column;
  logic                         image_done;

  logic [gcmf_pkg::WidthW-1:0]  w_eff;
  logic [gcmf_pkg::HeightW-1:0] h_eff;
  logic [gcmf_pkg::ColW-1:0]    pix_col;
  logic [gcmf_pkg::ColW-1:0]    fl_col;
  logic                         pix_col_last;
  logic                         fl_col_last;
  logic                         row_last;
  logic                         has_up;
  logic [gcmf_pkg::LumaW-1:0]   luma;
  logic                         accept;
  logic                         cfg_hit;

  always_comb begin
    if (image_width == '0) begin
      w_eff = gcmf_pkg::WidthW'(1);
    end else if (image_width > gcmf_pkg::WidthW'(gcmf_pkg::MaxWidth)) begin
      w_eff = gcmf_pkg::WidthW'(gcmf_pkg::MaxWidth);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == '0) ? gcmf_pkg::HeightW'(1) : image_height;
  end

  always_comb begin
    pix_col = (gcmf_pkg::WidthW'(in_column) < w_eff) ? in_column
            : gcmf_pkg::ColW'(w_eff - gcmf_pkg::WidthW'(1));
    fl_col  = (gcmf_pkg::WidthW'(out_column) < w_eff) ? out_column
            : gcmf_pkg::ColW'(w_eff - gcmf_pkg::WidthW'(1));
    pix_col_last = (gcmf_pkg::WidthW'(pix_col) + gcmf_pkg::WidthW'(1)) >= w_eff;
    fl_col_last  = (gcmf_pkg::WidthW'(fl_col) + gcmf_pkg::WidthW'(1)) >= w_eff;
    row_last = ({1'b0, in_row} + 17'd1) >= {1'b0, h_eff};
    has_up   = in_row >= gcmf_pkg::HeightW'(2);
  end

  assign luma = gcmf_pkg::LumaW'(red)   * gcmf_pkg::LumaW'(gcmf_pkg::LUMA_R)
              + gcmf_pkg::LumaW'(green) * gcmf_pkg::LumaW'(gcmf_pkg::LUMA_G)
              + gcmf_pkg::LumaW'(blue)  * gcmf_pkg::LumaW'(gcmf_pkg::LUMA_B);

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    push                = 1'b0;
    push_item.op        = gcmf_pkg::OP_PIXEL;
    push_item.col       = pix_col;
    push_item.gray      = luma[gcmf_pkg::LumaW-1 -: gcmf_pkg::GrayW];
    push_item.has_up    = has_up;
    push_item.has_left  = pix_col != '0;
    push_item.has_right = !pix_col_last;
    push_item.last      = 1'b0;
    if (accept) begin
      if (kind == gcmf_pkg::KIND_PIXEL) begin
        push         = !image_done;
        push_item.op = (in_row == '0) ? gcmf_pkg::OP_STORE : gcmf_pkg::OP_PIXEL;
      end else begin
        push                = image_done;
        push_item.op        = gcmf_pkg::OP_FLUSH;
        push_item.col       = fl_col;
        push_item.has_left  = fl_col != '0;
        push_item.has_right = !fl_col_last;
        push_item.last      = fl_col_last;
      end
    end
  end

  always_comb begin
    unique case (cfg_index)
      gcmf_pkg::REG_IMAGE_WIDTH:  cfg_hit = cfg_we;
      gcmf_pkg::REG_IMAGE_HEIGHT: cfg_hit = cfg_we;
      default:                    cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= gcmf_pkg::WIDTH_RESET;
      image_height <= gcmf_pkg::HEIGHT_RESET;
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      image_done   <= 1'b0;
    end else if (cfg_hit) begin
      if (cfg_index == gcmf_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg_data[gcmf_pkg::WidthW-1:0];
      end else begin
        image_height <= cfg_data[gcmf_pkg::HeightW-1:0];
      end
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      image_done <= 1'b0;
    end else if (push) begin
      if (push_item.op == gcmf_pkg::OP_FLUSH) begin
        if (fl_col_last) begin
          in_column  <= '0;
          in_row     <= '0;
          out_column <= '0;
          image_done <= 1'b0;
        end else begin
          out_column <= fl_col + gcmf_pkg::ColW'(1);
        end
      end else begin
        if (row_last && pix_col_last) begin
          image_done <= 1'b1;
        end
        if (pix_col_last) begin
          in_column <= '0;
          in_row    <= in_row + gcmf_pkg::HeightW'(1);
        end else begin
          in_column <= pix_col + gcmf_pkg::ColW'(1);
        end
      end
    end
  end

endmodule

// File: rtl/core/gcmf_fifo.sv
// gcmf_fifo: short queue of classified work between front and back
// depends on gcmf_pkg

module gcmf_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  gcmf_pkg::item_t      push_item,
  input  logic                 pop,
  output gcmf_pkg::item_t      head,
  output gcmf_pkg::q_status_t  status
);

  gcmf_pkg::item_t              slots [gcmf_pkg::QDepth];
  logic [gcmf_pkg::QPtrW-1:0]   wr_ptr;
  logic [gcmf_pkg::QPtrW-1:0]   rd_ptr;
  logic [gcmf_pkg::QPtrW:0]     count;

  assign head         = slots[rd_ptr];
  assign status.full  = count == (gcmf_pkg::QPtrW+1)'(gcmf_pkg::QDepth);
  assign status.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + gcmf_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + gcmf_pkg::QPtrW'(1);
      end
      if (push && !pop) begin
        count <= count + (gcmf_pkg::QPtrW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (gcmf_pkg::QPtrW+1)'(1);
      end
    end
  end

endmodule

// File: rtl/core/gcmf_back.sv
// gcmf_back: line stores, cross sum, divide by neighbor count and result register
// depends on gcmf_pkg; takes work from gcmf_fifo

module gcmf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  gcmf_pkg::q_status_t  q_status,
  input  gcmf_pkg::item_t      head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           filtered_value,
  output logic                 last_pixel
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SUM  = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [gcmf_pkg::GrayW-1:0] upper_mem  [gcmf_pkg::MaxWidth];
  logic [gcmf_pkg::GrayW-1:0] middle_mem [gcmf_pkg::MaxWidth];

  gcmf_pkg::item_t            cur;
  logic [gcmf_pkg::GrayW-1:0] mid_a;
  logic [gcmf_pkg::GrayW-1:0] mid_b;
  logic [gcmf_pkg::GrayW-1:0] up_q;
  logic [gcmf_pkg::GrayW-1:0] left_gray;
  logic [gcmf_pkg::SumW-1:0]  sum;
  logic [gcmf_pkg::CntW-1:0]  cnt;
  logic                       last;

  logic [gcmf_pkg::SumW-1:0]  sum_next;
  logic [gcmf_pkg::CntW-1:0]  cnt_next;
  logic                       mid_we;
  logic                       up_we;
  logic                       load;
  logic [gcmf_pkg::P3W-1:0]   p3;
  logic [gcmf_pkg::P5W-1:0]   p5;
  logic [gcmf_pkg::GrayW-1:0] quotient;

  assign pop    = (state == ST_IDLE) && !q_status.empty;
  assign mid_we = (state == ST_SUM) && (cur.op != gcmf_pkg::OP_FLUSH);
  assign up_we  = (state == ST_SUM) && (cur.op == gcmf_pkg::OP_PIXEL);
  assign load   = (state == ST_DIV) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (mid_we) begin
      middle_mem[cur.col] <= cur.gray;
    end
    if (pop) begin
      mid_a <= middle_mem[head.col];
      mid_b <= middle_mem[head.col + gcmf_pkg::ColW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (up_we) begin
      upper_mem[cur.col] <= mid_a;
    end
    if (pop) begin
      up_q <= upper_mem[head.col];
    end
  end

  always_comb begin
    sum_next = gcmf_pkg::SumW'(mid_a);
    cnt_next = gcmf_pkg::CntW'(1);
    if (cur.has_up) begin
      sum_next = sum_next + gcmf_pkg::SumW'(up_q);
      cnt_next = cnt_next + gcmf_pkg::CntW'(1);
    end
    if (cur.op == gcmf_pkg::OP_PIXEL) begin
      sum_next = sum_next + gcmf_pkg::SumW'(cur.gray);
      cnt_next = cnt_next + gcmf_pkg::CntW'(1);
    end
    if (cur.has_left) begin
      sum_next = sum_next + gcmf_pkg::SumW'(left_gray);
      cnt_next = cnt_next + gcmf_pkg::CntW'(1);
    end
    if (cur.has_right) begin
      sum_next = sum_next + gcmf_pkg::SumW'(mid_b);
      cnt_next = cnt_next + gcmf_pkg::CntW'(1);
    end
  end

  assign p3 = gcmf_pkg::P3W'(sum) * gcmf_pkg::P3W'(gcmf_pkg::Recip3);
  assign p5 = gcmf_pkg::P5W'(sum) * gcmf_pkg::P5W'(gcmf_pkg::Recip5);

  always_comb begin
    case (cnt)
      3'd2:    quotient = sum[1 +: gcmf_pkg::GrayW];
      3'd3:    quotient = p3[gcmf_pkg::Shift3 +: gcmf_pkg::GrayW];
      3'd4:    quotient = sum[2 +: gcmf_pkg::GrayW];
      3'd5:    quotient = p5[gcmf_pkg::Shift5 +: gcmf_pkg::GrayW];
      default: quotient = sum[gcmf_pkg::GrayW-1:0];
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        state_next = (cur.op == gcmf_pkg::OP_STORE) ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == ST_SUM) begin
      sum  <= sum_next;
      cnt  <= cnt_next;
      last <= cur.last;
      if (cur.op != gcmf_pkg::OP_STORE) begin
        left_gray <= mid_a;
      end
    end
    if (load) begin
      filtered_value <= quotient;
      last_pixel     <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
